/* sv/sspq_pkg.sv */
`default_nettype none

package sspq_pkg;

  // Default number of entries the queue can hold.
  localparam int unsigned CapacityDefault = 16;

  // Widths of the request and response fields.
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned OccW   = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One stored queue entry.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic insert;
    logic delete;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/sspq_cell.sv */
`default_nettype none

module sspq_cell (
  input  wire                      clk_i,
  input  wire sspq_pkg::cmd_t      cmd_i,
  input  wire                      occupied_i,
  input  wire                      left_after_i,
  input  wire sspq_pkg::entry_t    new_entry_i,
  input  wire sspq_pkg::entry_t    left_entry_i,
  input  wire sspq_pkg::entry_t    right_entry_i,
  output logic                     after_o,
  output sspq_pkg::entry_t         entry_o
);

  sspq_pkg::entry_t entry_q;
  sspq_pkg::entry_t entry_d;

  // The new entry belongs behind this cell when the cell holds an entry whose
  // priority is equal to or smaller than the new one.
  assign after_o = occupied_i && (entry_q.prio <= new_entry_i.prio);

  // On insert, cells in front of the slot hold, the slot takes the new entry
  // and the cells behind it move one place toward the tail. On delete every
  // cell takes its neighbor toward the tail.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      if (!after_o) begin
        entry_d = left_after_i ? new_entry_i : left_entry_i;
      end
    end else if (cmd_i.delete) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* sv/stable_sorted_priority_queue_top.sv */
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  opcode_i, item_value_i, item_priority_i
// response  out        out_valid_o / out_stall_i status_o, removed_value_o, occupancy_o
//
// Each request is handled at once: all cells compare the new priority against
// their own in parallel and the whole row shifts together.
// A response appears in the output register the cycle after its request.
// A new request is taken whenever that register is empty or being drained,
// so the queue sustains one request per cycle; only a stalled response holds it.
// Reset empties the queue; the cell contents are not cleared, since only cells
// below the fill count are ever read.

module stable_sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = sspq_pkg::CapacityDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  opcode_i,
  input  wire signed [sspq_pkg::ValueW-1:0]    item_value_i,
  input  wire        [sspq_pkg::PrioW-1:0]     item_priority_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic       [1:0]                     status_o,
  output logic signed [sspq_pkg::ValueW-1:0]   removed_value_o,
  output logic       [sspq_pkg::OccW-1:0]      occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Fill count of the cell row.
  logic [CntW-1:0] count_q, count_d;

  // Response register.
  logic                               out_valid_q, out_valid_d;
  sspq_pkg::status_e                  status_q, status_d;
  logic signed [sspq_pkg::ValueW-1:0] removed_q, removed_d;
  logic [sspq_pkg::OccW-1:0]          occ_q, occ_d;

  logic accept, is_insert, full, empty, do_insert, do_delete;
  logic [CntW+sspq_pkg::OccW-1:0] occ_wide;

  sspq_pkg::cmd_t   cmd;
  sspq_pkg::entry_t new_entry;
  sspq_pkg::entry_t cell_entry [CAPACITY];
  logic             cell_after [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_insert  = (sspq_pkg::op_e'(opcode_i) == sspq_pkg::OP_INSERT);
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign do_insert  = accept && is_insert && !full;
  assign do_delete  = accept && !is_insert && !empty;

  assign cmd.insert = do_insert;
  assign cmd.delete = do_delete;

  assign new_entry.value = item_value_i;
  assign new_entry.prio  = item_priority_i;

  // The row of cells: cell 0 is the front of the queue.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sspq_pkg::entry_t left_entry;
    sspq_pkg::entry_t right_entry;
    logic             left_after;

    if (i == 0) begin : g_front
      assign left_entry = new_entry;
      assign left_after = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    sspq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (count_q > CntW'(i)),
      .left_after_i  (left_after),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .after_o       (cell_after[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (do_delete) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Occupancy is the fill count after the request, cut to the field width.
  assign occ_wide = (CntW + sspq_pkg::OccW)'(count_d);
  assign occ_d    = occ_wide[sspq_pkg::OccW-1:0];

  always_comb begin
    status_d  = sspq_pkg::ST_DONE;
    removed_d = '0;
    if (is_insert && full) begin
      status_d = sspq_pkg::ST_FULL;
    end else if (!is_insert && empty) begin
      status_d = sspq_pkg::ST_EMPTY;
    end else if (!is_insert) begin
      removed_d = cell_entry[0].value;
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= occ_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = occ_q;

  // The fill count never passes the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // A refused insert leaves the fill count of the queue untouched.
  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_insert && full |=> $stable(count_q))
    else $error("refused insert changed the fill count");

  // A successful delete shrinks the queue by exactly one entry.
  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_delete |=> count_q == $past(count_q) - CntW'(1))
    else $error("delete did not remove exactly one entry");

  // Every accepted request leaves a response waiting in the output register.
  a_response : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no response");

  // The two front entries stay in priority order.
  a_front_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("front entries out of priority order");

endmodule

`default_nettype wire
